// ===== design/itc_pkg.sv =====
// Package for the three-counter interval timer.
// Holds item types, operation and register codes and counter constants.
// No dependencies.
package itc_pkg;

  localparam int unsigned NumCnt = 3;
  localparam int unsigned CntW   = 17;

  // Operation carried by one input transaction
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_GATE  = 2'd3
  } kind_e;

  // Bus address of the control word register
  localparam logic [1:0] ADDR_CTRL = 2'd3;

  // Read/load access codes of the control word
  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_WORD  = 2'd3;

  // Counter modes
  localparam logic [2:0] MODE_INT_TC   = 3'd0;
  localparam logic [2:0] MODE_RATE_GEN = 3'd2;
  localparam logic [2:0] MODE_SQUARE   = 3'd3;
  localparam logic [2:0] MODE_MAX      = 3'd5;

  // Count constants
  localparam logic [CntW-1:0] CNT_RESET   = 17'h0ffff;
  localparam logic [CntW-1:0] CNT_FULL    = 17'h10000;
  localparam logic [CntW-1:0] HALF_ODD_HI = 17'd32769;
  localparam logic [CntW-1:0] HALF_ODD_LO = 17'd32768;
  localparam logic [1:0]      START_DELAY = 2'd2;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] address;
    logic [7:0] write_data;
    logic [1:0] gate_select;
    logic       gate_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_zero;
    logic       out_one;
    logic       out_two;
  } out_item_t;

endpackage

// ===== design/itc_stream_if.sv =====
// Valid/ready channel used for the timer's input and result transactions.
// Depends on itc_pkg for the default payload type.
interface itc_stream_if import itc_pkg::*; #(
  parameter type T = in_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/interval_timer_three_channel.sv =====
// Three-counter interval timer, top level.
// Depends on itc_pkg and itc_stream_if.

// One transaction in, one result out, one transaction per clock: every bus write, bus read,
// counter tick or gate change is applied to the counter state in the cycle it is accepted,
// and its result (read byte plus the three output levels after the transaction) sits in an
// output register. The input is ready whenever that register is empty or being drained, so
// back-to-back transactions run at full rate; a stalled result stalls the input. Counting
// starts two ticks after a count load; a count of 0 loads as 65536.
module interval_timer_three_channel import itc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  itc_stream_if.sink   in_i,
  itc_stream_if.source out_o
);

  // Counter state
  logic [2:0]      mode_q    [NumCnt];
  logic [2:0]      mode_d    [NumCnt];
  logic [CntW-1:0] cnt_q     [NumCnt];
  logic [CntW-1:0] cnt_d     [NumCnt];
  logic [CntW-1:0] start_q   [NumCnt];
  logic [CntW-1:0] start_d   [NumCnt];
  logic [1:0]      dly_q     [NumCnt];
  logic [1:0]      dly_d     [NumCnt];
  logic            gate_q    [NumCnt];
  logic            gate_d    [NumCnt];
  logic            out_q     [NumCnt];
  logic            out_d     [NumCnt];
  logic            run_q     [NumCnt];
  logic            run_d     [NumCnt];
  logic [15:0]     latch_q   [NumCnt];
  logic [15:0]     latch_d   [NumCnt];
  logic            latched_q [NumCnt];
  logic            latched_d [NumCnt];
  logic [1:0]      acc_q     [NumCnt];
  logic [1:0]      acc_d     [NumCnt];
  logic            whigh_q   [NumCnt];
  logic            whigh_d   [NumCnt];
  logic            lvl       [NumCnt];

  logic            in_fire;
  logic            out_valid_q;
  out_item_t       out_data_q;
  out_item_t       res_d;
  logic [7:0]      rd_byte;
  in_item_t        item;

  assign item     = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  // Next state of every counter for the transaction on the input
  always_comb begin
    logic            adv_en, is_cw, is_wr, is_rd, is_gate, is_tick, dec, dd, do_load;
    logic [1:0]      rl;
    logic [2:0]      mw;
    logic [CntW-1:0] a_cnt, hi, lo, half, cur, nxt, r, ld;
    logic            a_out;
    logic [1:0]      a_dly;
    logic [CntW:0]   sub, r2, full;
    logic [15:0]     wv, rv;

    rd_byte = '0;
    if (item.kind == KIND_READ && item.address == ADDR_CTRL) begin
      rd_byte = 8'hff;
    end

    for (int c = 0; c < NumCnt; c++) begin
      is_tick = (item.kind == KIND_TICK);
      is_cw   = (item.kind == KIND_WRITE) && (item.address == ADDR_CTRL) &&
                (item.write_data[7:6] == 2'(c));
      is_wr   = (item.kind == KIND_WRITE) && (item.address == 2'(c));
      is_rd   = (item.kind == KIND_READ) && (item.address == 2'(c));
      is_gate = (item.kind == KIND_GATE) && (item.gate_select == 2'(c)) &&
                (item.gate_level != gate_q[c]);
      rl      = item.write_data[5:4];
      mw      = item.write_data[3:1];
      if (mw[2] && mw[1]) begin
        mw = {1'b0, mw[1:0]};
      end

      adv_en = is_tick || is_rd || is_gate ||
               (is_cw && (rl != ACC_LATCH || !latched_q[c])) ||
               (is_wr && (whigh_q[c] || acc_q[c] != ACC_WORD));

      // Bring the counter up to date (one tick or none)
      a_cnt = cnt_q[c];
      a_out = out_q[c];
      a_dly = dly_q[c];
      dec   = 1'b0;
      dd    = 1'b0;
      sub   = '0;
      hi    = '0;
      lo    = '0;
      half  = '0;
      cur   = '0;
      nxt   = '0;
      r     = '0;
      r2    = '0;
      full  = '0;
      if (adv_en) begin
        if (dly_q[c] != 2'd0) begin
          if (is_tick) a_dly = dly_q[c] - 2'd1;
        end else if (gate_q[c] && run_q[c]) begin
          unique case (mode_q[c])
            MODE_INT_TC: begin
              if (!out_q[c] && (cnt_q[c] == '0 || (is_tick && cnt_q[c] == 17'd1))) begin
                a_out = 1'b1;
              end
              if (is_tick) a_cnt = {1'b0, cnt_q[c][15:0] - 16'd1};
            end
            MODE_RATE_GEN: begin
              dec = is_tick && (start_q[c] != 17'd1);
              sub = {1'b0, cnt_q[c]} - {{CntW{1'b0}}, dec};
              if (sub == '0 || sub[CntW]) begin
                sub = sub + {1'b0, start_q[c]};
              end
              a_out = (sub != 18'd1);
              a_cnt = sub[CntW-1:0];
            end
            MODE_SQUARE: begin
              // half periods, with the odd cases for counts of one and three
              hi = CntW'(({1'b0, start_q[c]} + 18'd1) >> 1);
              lo = start_q[c] >> 1;
              if (start_q[c] == 17'd3) begin
                lo = HALF_ODD_HI;
              end else if (start_q[c] == 17'd1) begin
                hi = HALF_ODD_HI;
                lo = HALF_ODD_LO;
              end
              full = {1'b0, hi} + {1'b0, lo};
              half = out_q[c] ? CntW'(({1'b0, cnt_q[c]} + 18'd1) >> 1) : (cnt_q[c] >> 1);
              cur  = out_q[c] ? hi : lo;
              nxt  = out_q[c] ? lo : hi;
              if ({{(CntW-1){1'b0}}, is_tick} < half) begin
                r = half - {{(CntW-1){1'b0}}, is_tick};
              end else begin
                dd = is_tick && !half[0];
                if ({{(CntW-1){1'b0}}, dd} < nxt) begin
                  r     = nxt - {{(CntW-1){1'b0}}, dd};
                  a_out = !out_q[c];
                end else begin
                  r = cur;
                end
              end
              r2 = {r, 1'b0};
              if (r2 > full) r2 = r2 - 18'd1;
              a_cnt = r2[CntW-1:0];
            end
            default: ;
          endcase
        end
      end

      mode_d[c]    = mode_q[c];
      cnt_d[c]     = a_cnt;
      start_d[c]   = start_q[c];
      dly_d[c]     = a_dly;
      gate_d[c]    = gate_q[c];
      out_d[c]     = a_out;
      run_d[c]     = run_q[c];
      latch_d[c]   = latch_q[c];
      latched_d[c] = latched_q[c];
      acc_d[c]     = acc_q[c];
      whigh_d[c]   = whigh_q[c];
      do_load      = 1'b0;
      wv           = '0;
      rv           = '0;
      ld           = '0;

      // Control word: latch command or mode/access programming
      if (is_cw) begin
        if (rl == ACC_LATCH) begin
          if (!latched_q[c]) begin
            latched_d[c] = 1'b1;
            latch_d[c]   = a_cnt[15:0];
            whigh_d[c]   = 1'b0;
          end
        end else begin
          latch_d[c]   = '0;
          acc_d[c]     = rl;
          latched_d[c] = 1'b0;
          whigh_d[c]   = (rl == ACC_HIGH);
          mode_d[c]    = mw;
          run_d[c]     = 1'b0;
          out_d[c]     = (mw != MODE_INT_TC);
        end
      end

      // Data write: byte assembly and count load
      if (is_wr) begin
        if (!whigh_q[c]) begin
          wv = {latch_q[c][15:8], item.write_data};
          if (acc_q[c] == ACC_WORD) begin
            whigh_d[c] = 1'b1;
            if (mode_q[c] == MODE_INT_TC) run_d[c] = 1'b0;
          end else begin
            do_load = 1'b1;
          end
        end else begin
          wv = {item.write_data, latch_q[c][7:0]};
          if (acc_q[c] == ACC_WORD) whigh_d[c] = 1'b0;
          do_load = 1'b1;
        end
        latch_d[c] = wv;
        if (do_load) begin
          ld         = (wv == '0) ? CNT_FULL : {1'b0, wv};
          start_d[c] = ld;
          unique case (mode_q[c])
            MODE_INT_TC: begin
              cnt_d[c] = ld;
              run_d[c] = 1'b1;
              out_d[c] = 1'b0;
              dly_d[c] = START_DELAY;
            end
            MODE_RATE_GEN, MODE_SQUARE: begin
              if (!run_q[c]) cnt_d[c] = ld;
              run_d[c] = 1'b1;
              dly_d[c] = START_DELAY;
            end
            default: ;
          endcase
        end
      end

      // Data read
      if (is_rd) begin
        rv      = latched_q[c] ? latch_q[c] : a_cnt[15:0];
        rd_byte = whigh_q[c] ? rv[15:8] : rv[7:0];
        if (whigh_q[c]) latched_d[c] = 1'b0;
        if (acc_q[c] == ACC_WORD) whigh_d[c] = !whigh_q[c];
      end

      // Gate level change
      if (is_gate) begin
        gate_d[c] = item.gate_level;
        unique case (mode_q[c])
          MODE_INT_TC: run_d[c] = item.gate_level;
          MODE_RATE_GEN, MODE_SQUARE: begin
            run_d[c] = item.gate_level;
            out_d[c] = !item.gate_level;
            if (item.gate_level) cnt_d[c] = start_q[c];
          end
          default: ;
        endcase
      end

      // Output pin level after the transaction
      unique case (mode_d[c])
        MODE_INT_TC:                lvl[c] = out_d[c];
        MODE_RATE_GEN, MODE_SQUARE: lvl[c] = (run_d[c] && out_d[c]) || !gate_d[c];
        default:                    lvl[c] = 1'b1;
      endcase
    end

    res_d.read_data = rd_byte;
    res_d.out_zero  = lvl[0];
    res_d.out_one   = lvl[1];
    res_d.out_two   = lvl[2];
  end

  // Counter state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCnt; c++) begin
        mode_q[c]    <= MODE_INT_TC;
        cnt_q[c]     <= CNT_RESET;
        start_q[c]   <= CNT_RESET;
        dly_q[c]     <= '0;
        gate_q[c]    <= 1'b1;
        out_q[c]     <= 1'b0;
        run_q[c]     <= 1'b0;
        latch_q[c]   <= '0;
        latched_q[c] <= 1'b0;
        acc_q[c]     <= ACC_LATCH;
        whigh_q[c]   <= 1'b0;
      end
    end else if (in_fire) begin
      for (int c = 0; c < NumCnt; c++) begin
        mode_q[c]    <= mode_d[c];
        cnt_q[c]     <= cnt_d[c];
        start_q[c]   <= start_d[c];
        dly_q[c]     <= dly_d[c];
        gate_q[c]    <= gate_d[c];
        out_q[c]     <= out_d[c];
        run_q[c]     <= run_d[c];
        latch_q[c]   <= latch_d[c];
        latched_q[c] <= latched_d[c];
        acc_q[c]     <= acc_d[c];
        whigh_q[c]   <= whigh_d[c];
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  for (genvar g = 0; g < NumCnt; g++) begin : g_chk
    a_start_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      start_q[g] != '0)
      else $error("counter %0d holds a zero initial count", g);

    a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      mode_q[g] <= MODE_MAX)
      else $error("counter %0d mode out of range", g);

    a_whigh_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (acc_q[g] == ACC_LOW || acc_q[g] == ACC_LATCH) |-> !whigh_q[g])
      else $error("counter %0d high-byte pointer set in low-byte access", g);
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while result register is stalled");
`endif

endmodule

// ===== sim/timer_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the three-counter interval timer: watches both channels,
// predicts every result transaction and compares it field by field.
// Depends on itc_pkg.
module timer_result_checker import itc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Predicted counter state, one entry per counter
  logic [2:0]      cnt_mode   [NumCnt];
  logic [CntW-1:0] cnt_val    [NumCnt];
  logic [CntW-1:0] cnt_init   [NumCnt];
  logic [1:0]      cnt_delay  [NumCnt];
  logic            cnt_gate   [NumCnt];
  logic            cnt_out    [NumCnt];
  logic            cnt_run    [NumCnt];
  logic [15:0]     cnt_hold   [NumCnt];
  logic            cnt_held   [NumCnt];
  logic [1:0]      cnt_acc    [NumCnt];
  logic            cnt_hiwait [NumCnt];

  out_item_t predicted_out_q [$];
  out_item_t want;
  int        mismatches;

  assign fail_count_o = mismatches;

  function automatic void clear_counters();
    for (int c = 0; c < NumCnt; c++) begin
      cnt_mode[c]   = MODE_INT_TC;
      cnt_val[c]    = CNT_RESET;
      cnt_init[c]   = CNT_RESET;
      cnt_delay[c]  = '0;
      cnt_gate[c]   = 1'b1;
      cnt_out[c]    = 1'b0;
      cnt_run[c]    = 1'b0;
      cnt_hold[c]   = '0;
      cnt_held[c]   = 1'b0;
      cnt_acc[c]    = ACC_LATCH;
      cnt_hiwait[c] = 1'b0;
    end
  endfunction

  // Bring one counter up to date; tick = 1 for a counter clock, 0 for a bus sync
  function automatic void advance_counter(int c, bit tick);
    int init, cur, cnt, tt, hi, lo, full, last, this_half, next_half;
    if (cnt_delay[c] != 2'd0) begin
      if (tick) cnt_delay[c] = cnt_delay[c] - 2'd1;
      return;
    end
    if (!cnt_gate[c] || !cnt_run[c]) return;
    tt   = tick;
    init = cnt_init[c];
    cur  = cnt_val[c];
    case (cnt_mode[c])
      MODE_INT_TC: begin
        if (!cnt_out[c] && tt >= cur) cnt_out[c] = 1'b1;
        if (tick) cnt_val[c] = {1'b0, cnt_val[c][15:0] - 16'd1};
      end
      MODE_RATE_GEN: begin
        if (init != 0 && tt >= init) tt -= init;
        cnt = cur - tt;
        if (cnt <= 0) cnt += init;
        cnt_out[c] = (cnt != 1);
        cnt_val[c] = cnt[CntW-1:0];
      end
      MODE_SQUARE: begin
        // half periods; odd counts 1 and 3 use the long special halves
        hi = (init + 1) / 2;
        lo = init / 2;
        if (init == 3) begin
          lo = HALF_ODD_HI;
        end else if (init == 1) begin
          hi = HALF_ODD_HI;
          lo = HALF_ODD_LO;
        end
        full      = hi + lo;
        cnt       = cnt_out[c] ? (cur + 1) / 2 : cur / 2;
        last      = cnt;
        this_half = cnt_out[c] ? hi : lo;
        next_half = cnt_out[c] ? lo : hi;
        if (tt < last) begin
          cnt -= tt;
        end else if (tt < last + next_half) begin
          cnt        = next_half - (tt - last);
          cnt_out[c] = !cnt_out[c];
        end else begin
          cnt = this_half - (tt - last - next_half);
        end
        cnt = cnt * 2;
        if (cnt > full) cnt--;
        cnt_val[c] = cnt[CntW-1:0];
      end
      default: ;
    endcase
  endfunction

  function automatic logic out_level(int c);
    case (cnt_mode[c])
      MODE_INT_TC:                return cnt_out[c];
      MODE_RATE_GEN, MODE_SQUARE: return (cnt_run[c] && cnt_out[c]) || !cnt_gate[c];
      default:                    return 1'b1;
    endcase
  endfunction

  function automatic void load_counter(int c, logic [15:0] v);
    advance_counter(c, 1'b0);
    cnt_init[c] = (v == 16'd0) ? CNT_FULL : {1'b0, v};
    case (cnt_mode[c])
      MODE_INT_TC: begin
        cnt_val[c]   = cnt_init[c];
        cnt_run[c]   = 1'b1;
        cnt_out[c]   = 1'b0;
        cnt_delay[c] = START_DELAY;
      end
      MODE_RATE_GEN, MODE_SQUARE: begin
        if (!cnt_run[c]) cnt_val[c] = cnt_init[c];
        cnt_run[c]   = 1'b1;
        cnt_delay[c] = START_DELAY;
      end
      default: ;
    endcase
  endfunction

  function automatic void set_gate(int c, logic g);
    if (g == cnt_gate[c]) return;
    advance_counter(c, 1'b0);
    cnt_gate[c] = g;
    case (cnt_mode[c])
      MODE_INT_TC: cnt_run[c] = g;
      MODE_RATE_GEN, MODE_SQUARE: begin
        cnt_run[c] = g;
        cnt_out[c] = !g;
        if (g) cnt_val[c] = cnt_init[c];
      end
      default: ;
    endcase
  endfunction

  // Control word or data byte written on the bus
  function automatic void bus_write(logic [1:0] addr, logic [7:0] v);
    logic [1:0] sel;
    logic [1:0] rl;
    logic [2:0] m;
    int         c;
    if (addr == ADDR_CTRL) begin
      sel = v[7:6];
      rl  = v[5:4];
      m   = v[3:1];
      if (sel >= NumCnt) return;
      c = sel;
      if (m > MODE_MAX) m = {1'b0, m[1:0]};
      if (rl == ACC_LATCH) begin
        // a second latch before the first is read out is dropped
        if (!cnt_held[c]) begin
          advance_counter(c, 1'b0);
          cnt_held[c]   = 1'b1;
          cnt_hold[c]   = cnt_val[c][15:0];
          cnt_hiwait[c] = 1'b0;
        end
      end else begin
        cnt_hold[c]   = '0;
        cnt_acc[c]    = rl;
        cnt_held[c]   = 1'b0;
        cnt_hiwait[c] = (rl == ACC_HIGH);
        advance_counter(c, 1'b0);
        cnt_mode[c] = m;
        cnt_run[c]  = 1'b0;
        cnt_out[c]  = (m != MODE_INT_TC);
      end
    end else begin
      c = addr;
      if (!cnt_hiwait[c]) begin
        cnt_hold[c][7:0] = v;
        if (cnt_acc[c] == ACC_WORD) begin
          cnt_hiwait[c] = 1'b1;
          if (cnt_mode[c] == MODE_INT_TC) cnt_run[c] = 1'b0;
        end else begin
          load_counter(c, cnt_hold[c]);
        end
      end else begin
        cnt_hold[c][15:8] = v;
        if (cnt_acc[c] == ACC_WORD) cnt_hiwait[c] = 1'b0;
        load_counter(c, cnt_hold[c]);
      end
    end
  endfunction

  function automatic logic [7:0] bus_read(logic [1:0] addr);
    logic [15:0] val;
    logic [7:0]  res;
    int          c;
    if (addr == ADDR_CTRL) return 8'hff;
    c = addr;
    advance_counter(c, 1'b0);
    val = cnt_held[c] ? cnt_hold[c] : cnt_val[c][15:0];
    res = cnt_hiwait[c] ? val[15:8] : val[7:0];
    // only a high-byte read releases a latched count
    if (cnt_hiwait[c]) cnt_held[c] = 1'b0;
    if (cnt_acc[c] == ACC_WORD) cnt_hiwait[c] = !cnt_hiwait[c];
    return res;
  endfunction

  // Apply one input transaction and return the result it should produce
  function automatic out_item_t timer_apply(in_item_t it);
    out_item_t r;
    r.read_data = '0;
    case (it.kind)
      KIND_WRITE: bus_write(it.address, it.write_data);
      KIND_READ:  r.read_data = bus_read(it.address);
      KIND_TICK:  for (int c = 0; c < NumCnt; c++) advance_counter(c, 1'b1);
      default:    if (it.gate_select < NumCnt) set_gate(it.gate_select, it.gate_level);
    endcase
    r.out_zero = out_level(0);
    r.out_one  = out_level(1);
    r.out_two  = out_level(2);
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Compare results first, then record the prediction for a new transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_counters();
      predicted_out_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_out_q.size() == 0) begin
          $error("result transaction with nothing predicted: read_data %0d",
                 out_data_i.read_data);
          mismatches++;
        end else begin
          want = predicted_out_q.pop_front();
          check_field("read_data", want.read_data, out_data_i.read_data);
          check_field("out_zero", 8'(want.out_zero), 8'(out_data_i.out_zero));
          check_field("out_one", 8'(want.out_one), 8'(out_data_i.out_one));
          check_field("out_two", 8'(want.out_two), 8'(out_data_i.out_two));
        end
      end
      if (in_valid_i && in_ready_i) predicted_out_q.push_back(timer_apply(in_data_i));
      pending_o <= predicted_out_q.size();
    end
  end

endmodule

// ===== sim/tb_interval_timer_three_channel.sv =====
`timescale 1ns / 1ps
// Testbench top for the three-counter interval timer: drives bus, tick and gate
// transactions and gives the verdict. Depends on itc_pkg, itc_stream_if,
// interval_timer_three_channel and timer_result_checker.
module tb_interval_timer_three_channel;
  import itc_pkg::*;

  localparam int RandomItems = 1150;
  localparam int CycleLimit  = 200000;
  localparam int StallCycles = 150;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   stall_reqs;
  int   stall_seen;
  int   stall_left;
  int   cycle_cnt;
  int   sent;

  itc_stream_if #(.T(in_item_t))  in_if ();
  itc_stream_if #(.T(out_item_t)) res_if ();

  interval_timer_three_channel uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (res_if)
  );

  timer_result_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (res_if.valid),
    .out_ready_i  (res_if.ready),
    .out_data_i   (res_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_interval_timer_three_channel failed");
      $finish;
    end
  end

  // Result side: random back-pressure plus long hold-offs on request
  initial begin
    res_if.ready <= 1'b0;
    stall_seen = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_reqs != stall_seen) begin
        stall_seen = stall_reqs;
        stall_left = StallCycles;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind        = kind_e'($urandom_range(3));
    it.address     = 2'($urandom_range(3));
    it.write_data  = 8'($urandom_range(255));
    it.gate_select = 2'($urandom_range(3));
    it.gate_level  = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_item_t bus_wr(logic [1:0] addr, logic [7:0] v);
    in_item_t it;
    it            = noise_item();
    it.kind       = KIND_WRITE;
    it.address    = addr;
    it.write_data = v;
    return it;
  endfunction

  function automatic in_item_t bus_rd(logic [1:0] addr);
    in_item_t it;
    it         = noise_item();
    it.kind    = KIND_READ;
    it.address = addr;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it      = noise_item();
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic in_item_t gate_item(logic [1:0] sel, logic lvl);
    in_item_t it;
    it             = noise_item();
    it.kind        = KIND_GATE;
    it.gate_select = sel;
    it.gate_level  = lvl;
    return it;
  endfunction

  // Control word: counter select, read/load access, mode, BCD bit
  function automatic logic [7:0] ctrl_word(logic [1:0] sel, logic [1:0] rl, logic [2:0] m);
    return {sel, rl, m, 1'($urandom_range(1))};
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic issue(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    // transactions the timer drops do not count
    if (!((it.kind == KIND_GATE && it.gate_select == 2'd3) ||
          (it.kind == KIND_WRITE && it.address == ADDR_CTRL && it.write_data[7:6] == 2'd3)))
      sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Program one counter with a mostly small count, then run it with ticks, reads and gates
  task automatic program_and_run();
    logic [1:0]  sel;
    logic [1:0]  rl;
    logic [2:0]  m;
    logic [15:0] cnt;
    int          len;
    int          r;
    sel = 2'($urandom_range(2));
    rl  = 2'($urandom_range(3, 1));
    if ($urandom_range(3) == 0) begin
      m = 3'($urandom_range(7));
    end else begin
      case ($urandom_range(2))
        0:       m = MODE_INT_TC;
        1:       m = MODE_RATE_GEN;
        default: m = MODE_SQUARE;
      endcase
    end
    r = $urandom_range(9);
    if (r < 7)       cnt = 16'($urandom_range(12, 1));
    else if (r == 7) cnt = 16'd0;
    else if (r == 8) cnt = 16'($urandom_range(40, 13));
    else             cnt = 16'($urandom_range(16'hffff));
    issue(bus_wr(ADDR_CTRL, ctrl_word(sel, rl, m)));
    case (rl)
      ACC_LOW:  issue(bus_wr(sel, cnt[7:0]));
      ACC_HIGH: issue(bus_wr(sel, cnt[15:8]));
      default: begin
        issue(bus_wr(sel, cnt[7:0]));
        issue(bus_wr(sel, cnt[15:8]));
      end
    endcase
    len = $urandom_range(40, 5);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 62)      issue(tick_item());
      else if (r < 74) issue(bus_rd(($urandom_range(4) == 0) ? 2'($urandom_range(3)) : sel));
      else if (r < 80) issue(bus_wr(ADDR_CTRL, ctrl_word(sel, ACC_LATCH, 3'($urandom_range(7)))));
      else if (r < 90) issue(gate_item(sel, 1'($urandom_range(1))));
      else if (r < 95) issue(bus_wr(sel, 8'($urandom_range(6))));
      else             issue(noise_item());
    end
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    int want_phase;
    bit stalled;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_ni      <= 1'b0;
    cycle_cnt   = 0;
    stall_reqs  = 0;
    sent        = 0;
    src_idle_pct = 31;
    snk_idle_pct = 81;
    phase   = 0;
    stalled = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: control port read, mode 0 count of 2, double latch,
    // rate generator with count 1, square wave with count 3 via mode 7,
    // control word for the non-existent counter, gate edge cases
    issue(bus_rd(ADDR_CTRL));
    issue(bus_wr(ADDR_CTRL, ctrl_word(2'd0, ACC_WORD, MODE_INT_TC)));
    issue(bus_wr(2'd0, 8'h02));
    issue(bus_wr(2'd0, 8'h00));
    repeat (4) issue(tick_item());
    issue(bus_wr(ADDR_CTRL, ctrl_word(2'd0, ACC_LATCH, MODE_INT_TC)));
    issue(bus_wr(ADDR_CTRL, ctrl_word(2'd0, ACC_LATCH, MODE_INT_TC)));
    issue(bus_rd(2'd0));
    issue(bus_rd(2'd0));
    issue(bus_wr(ADDR_CTRL, ctrl_word(2'd1, ACC_LOW, MODE_RATE_GEN)));
    issue(bus_wr(2'd1, 8'h01));
    issue(bus_wr(ADDR_CTRL, ctrl_word(2'd2, ACC_WORD, 3'd7)));
    issue(bus_wr(2'd2, 8'h03));
    issue(bus_wr(2'd2, 8'h00));
    issue(bus_wr(ADDR_CTRL, 8'hff));
    issue(gate_item(2'd2, 1'b0));
    issue(gate_item(2'd3, 1'b0));
    issue(gate_item(2'd2, 1'b0));
    issue(gate_item(2'd2, 1'b1));
    repeat (5) issue(tick_item());

    // Random part in three idling phases
    sent = 0;
    while (sent < RandomItems) begin
      want_phase = (sent < 380) ? 0 : (sent < 770) ? 1 : 2;
      if (want_phase != phase) begin
        wait_drained();
        phase = want_phase;
        src_idle_pct = (phase == 1) ? 81 : 0;
        snk_idle_pct = (phase == 1) ? 31 : 0;
      end
      if (phase == 2 && !stalled && sent > 900) begin
        stall_reqs++;
        stalled = 1'b1;
      end
      if ($urandom_range(4) != 0) begin
        program_and_run();
      end else begin
        repeat ($urandom_range(4, 1)) issue(noise_item());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_interval_timer_three_channel passed");
    end else begin
      $display("tb_interval_timer_three_channel failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/itc_pkg.sv
design/itc_stream_if.sv
design/interval_timer_three_channel.sv
sim/timer_result_checker.sv
sim/tb_interval_timer_three_channel.sv
